FILE: hw/rtl/drd_pkg.sv
// ---------------------------------------------------------------------------
// Dump record deframer package
// Transaction types and result codes shared by the deframer.
// ---------------------------------------------------------------------------
package drd_pkg;

  typedef enum logic [2:0] {
    KIND_DATA       = 3'd0,
    KIND_FILE_START = 3'd1,
    KIND_END_RECORD = 3'd2,
    KIND_END_FILE   = 3'd3,
    KIND_DONE       = 3'd4,
    KIND_NO_CATALOG = 3'd5,
    KIND_TRUNCATED  = 3'd6
  } kind_e;

  localparam logic [2:0] BLOCK_CATALOG = 3'd1;
  localparam logic [2:0] BLOCK_DATA    = 3'd3;
  localparam logic [2:0] FLAG_MAX      = 3'd3;
  localparam logic [2:0] CAT_TIME_WORD = 3'd4;
  localparam logic [8:0] CAT_MIN_LEN   = 9'd4;

  localparam logic [1:0] MARK_NONE       = 2'd0;
  localparam logic [1:0] MARK_END_RECORD = 2'd1;
  localparam logic [1:0] MARK_END_FILE   = 2'd2;

  typedef struct packed {
    logic [59:0] word;
    logic        record_end;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [59:0] data_word;
    logic [17:0] user_index;
    logic [5:0]  year_offset;
    logic [5:0]  month;
    logic [5:0]  day;
    logic [5:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        last;
  } out_item_t;

endpackage

FILE: hw/rtl/dump_record_deframer.sv
// ---------------------------------------------------------------------------
// Dump record deframer
// Splits a stream of 60-bit dump words into catalog, data, mark and record status results.
// ---------------------------------------------------------------------------
// The input channel (in_valid_i, in_stall_o, in_item_i) carries one 60-bit
// word per transaction, or a record end marker. The output channel
// (out_valid_o, out_stall_i, out_item_o) carries result transactions; an
// input word causes none, one or two of them, and the last flag marks the
// final result caused by a given word.
// An accepted word is held in an input register and decoded from there;
// its results are registered in the result buffer before they are offered
// on the output channel. The
// decoding logic writes into a two-slot result buffer; a word is decoded as
// soon as the buffer has room for all of its results, so one word is taken
// every cycle while the receiver keeps up and the buffer has that room; a
// data word that closes a block with a mark yields a data and a mark result.
// While the receiver stalls, the buffer fills and the input register then
// holds its word, which raises in_stall_o. Reset empties both registers and
// returns the framing state to waiting for a control word with no catalog
// seen; a record end marker does the same after reporting its status.
// ---------------------------------------------------------------------------
module dump_record_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  drd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output drd_pkg::out_item_t out_item_o
);
  import drd_pkg::*;

  typedef enum logic [1:0] {
    PH_CTRL = 2'd0,
    PH_CAT  = 2'd1,
    PH_DATA = 2'd2,
    PH_SKIP = 2'd3
  } phase_e;

  logic        in_valid_q, in_valid_d;
  in_item_t    in_q;
  phase_e      phase_q, phase_d;
  logic [8:0]  words_left_q, words_left_d;
  logic [2:0]  cat_idx_q, cat_idx_d;
  logic [1:0]  mark_q, mark_d;
  logic        seen_q, seen_d;
  logic [17:0] held_q, held_d;
  logic [1:0]  count_q, count_d;
  out_item_t   slot0_q, slot0_d, slot1_q, slot1_d;

  out_item_t   res0, res1, kept0;
  logic [1:0]  n_res, free, cnt_pop;
  logic        fire, pop;
  logic [59:0] w;
  logic [2:0]  blk, flag;
  logic [8:0]  len, wl_dec;
  logic [1:0]  mk;

  assign w    = in_q.word;
  assign blk  = w[14:12];
  assign flag = w[11:9];
  assign len  = w[8:0];
  assign wl_dec = words_left_q - 9'd1;

  always_comb begin
    phase_d      = phase_q;
    words_left_d = words_left_q;
    cat_idx_d    = cat_idx_q;
    mark_d       = mark_q;
    seen_d       = seen_q;
    held_d       = held_q;
    res0         = '0;
    res1         = '0;
    n_res        = 2'd0;
    mk           = MARK_NONE;
    if (in_q.record_end) begin
      n_res = 2'd1;
      if (phase_q == PH_CAT || phase_q == PH_DATA) begin
        res0.kind = KIND_TRUNCATED;
      end else if (seen_q) begin
        res0.kind = KIND_DONE;
      end else begin
        res0.kind = KIND_NO_CATALOG;
      end
      phase_d      = PH_CTRL;
      words_left_d = '0;
      cat_idx_d    = '0;
      mark_d       = MARK_NONE;
      seen_d       = 1'b0;
      held_d       = '0;
    end else begin
      case (phase_q)
        PH_CTRL: begin
          if (flag == 3'd1) begin
            mk = MARK_END_RECORD;
          end else if (flag == 3'd2) begin
            mk = MARK_END_FILE;
          end
          if (blk == BLOCK_CATALOG) begin
            phase_d      = PH_CAT;
            cat_idx_d    = 3'd1;
            words_left_d = len;
          end else if (blk == BLOCK_DATA && flag <= FLAG_MAX) begin
            if (len == '0) begin
              if (seen_q && mk != MARK_NONE) begin
                n_res     = 2'd1;
                res0.kind = kind_e'({1'b0, mk} + 3'd1);
              end
            end else begin
              phase_d      = PH_DATA;
              words_left_d = len;
              mark_d       = mk;
            end
          end else begin
            words_left_d = len;
            phase_d      = (len != '0) ? PH_SKIP : PH_CTRL;
          end
        end
        PH_CAT: begin
          if (cat_idx_q == 3'd1) begin
            held_d = w[17:0];
          end
          if (cat_idx_q >= CAT_TIME_WORD) begin
            n_res            = 2'd1;
            res0.kind        = KIND_FILE_START;
            res0.user_index  = held_q;
            res0.year_offset = w[35:30];
            res0.month       = w[29:24];
            res0.day         = w[23:18];
            res0.hour        = w[17:12];
            res0.minute      = w[11:6];
            res0.second      = w[5:0];
            seen_d           = 1'b1;
            cat_idx_d        = '0;
            if (words_left_q > CAT_MIN_LEN) begin
              words_left_d = words_left_q - CAT_MIN_LEN;
              phase_d      = PH_SKIP;
            end else begin
              words_left_d = '0;
              phase_d      = PH_CTRL;
            end
          end else begin
            cat_idx_d = cat_idx_q + 3'd1;
          end
        end
        PH_DATA: begin
          words_left_d = wl_dec;
          if (seen_q) begin
            res0.kind      = KIND_DATA;
            res0.data_word = w;
          end
          if (wl_dec == '0) begin
            phase_d = PH_CTRL;
            mark_d  = MARK_NONE;
          end
          if (seen_q && wl_dec == '0 && mark_q != MARK_NONE) begin
            n_res     = 2'd2;
            res1.kind = kind_e'({1'b0, mark_q} + 3'd1);
          end else if (seen_q) begin
            n_res = 2'd1;
          end
        end
        default: begin
          words_left_d = wl_dec;
          if (wl_dec == '0) begin
            phase_d = PH_CTRL;
          end
        end
      endcase
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  assign pop     = (count_q != 2'd0) && !out_stall_i;
  assign cnt_pop = count_q - {1'b0, pop};
  assign free    = 2'd2 - cnt_pop;
  assign fire    = in_valid_q && (n_res <= free);
  assign kept0   = pop ? slot1_q : slot0_q;

  assign in_stall_o  = in_valid_q && !fire;
  assign out_valid_o = (count_q != 2'd0);
  assign out_item_o  = slot0_q;

  always_comb begin
    in_valid_d = fire ? 1'b0 : in_valid_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end
    slot0_d = (cnt_pop != 2'd0) ? kept0 : res0;
    if (cnt_pop == 2'd2) begin
      slot1_d = slot1_q;
    end else if (cnt_pop == 2'd1) begin
      slot1_d = res0;
    end else begin
      slot1_d = res1;
    end
    count_d = fire ? cnt_pop + n_res : cnt_pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      count_q      <= 2'd0;
      phase_q      <= PH_CTRL;
      words_left_q <= '0;
      cat_idx_q    <= '0;
      mark_q       <= MARK_NONE;
      seen_q       <= 1'b0;
      held_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      count_q    <= count_d;
      if (fire) begin
        phase_q      <= phase_d;
        words_left_q <= words_left_d;
        cat_idx_q    <= cat_idx_d;
        mark_q       <= mark_d;
        seen_q       <= seen_d;
        held_q       <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_item_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_q))
    else $error("undecoded word lost from input register");

  a_record_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_q.record_end |=> phase_q == PH_CTRL && !seen_q && mark_q == MARK_NONE)
    else $error("framing state not cleared after record end");

  a_cat_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CAT |-> cat_idx_q >= 3'd1 && cat_idx_q <= CAT_TIME_WORD)
    else $error("catalog word index out of range");

endmodule
